// File: rtl/cte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_pkg
// Shared codes and types of the connection table engine: operation and
// status codes, the scan item that travels down the cell chain and the
// write command that the controller sends to every cell.
// ----------------------------------------------------------------------------
package cte_pkg;

  localparam int DEF_TABLE_DEPTH = 16;

  // operation codes
  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_UPDATE = 2'd2;
  localparam logic [1:0] FN_QUERY  = 2'd3;

  // status codes
  localparam logic [3:0] STAT_ADDED    = 4'd0;
  localparam logic [3:0] STAT_DUP_ADDR = 4'd1;
  localparam logic [3:0] STAT_DUP_SOCK = 4'd2;
  localparam logic [3:0] STAT_FULL     = 4'd3;
  localparam logic [3:0] STAT_REMOVED  = 4'd4;
  localparam logic [3:0] STAT_UPDATED  = 4'd5;
  localparam logic [3:0] STAT_MISSING  = 4'd6;
  localparam logic [3:0] STAT_FOUND    = 4'd7;
  localparam logic [3:0] STAT_ABSENT   = 4'd8;

  // write command kinds
  localparam logic [1:0] WR_APPEND = 2'd0;
  localparam logic [1:0] WR_MOVE   = 2'd1;
  localparam logic [1:0] WR_PORT   = 2'd2;

  // scan item handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic [1:0]  func;
    logic [15:0] socket_id;
    logic [31:0] address;
    logic [15:0] port_number;
    logic        decided;
    logic        addr_hit;
    logic [15:0] last_socket;
    logic [31:0] last_address;
    logic [15:0] last_port;
  } tok_t;

  // write command broadcast to the cells
  typedef struct packed {
    logic        en;
    logic [1:0]  mode;
    logic [15:0] socket_id;
    logic [31:0] address;
    logic [15:0] port_number;
  } wr_t;

endpackage

// File: rtl/cte_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_cell
// One table entry. Compares its entry against the passing scan item, marks
// the first match, hands the item on to the next cell and applies writes.
// ----------------------------------------------------------------------------
module cte_cell
  import cte_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int IDX         = 0,
  localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [CW-1:0] count_i,
  input  wr_t           wr_i,
  input  tok_t          tok_i,
  output tok_t          tok_o
);

  logic [15:0] ent_sock_q;
  logic [31:0] ent_addr_q;
  logic [15:0] ent_port_q;
  logic        hit_q, hit_d;
  tok_t        tok_q, tok_d;
  logic        in_use, is_last, addr_eq, sock_eq;
  logic        wr_all, wr_port;

  assign in_use  = CW'(IDX) < count_i;
  assign is_last = CW'(IDX + 1) == count_i;
  assign addr_eq = in_use && (ent_addr_q == tok_i.address) &&
                   (ent_port_q == tok_i.port_number);
  assign sock_eq = in_use && (ent_sock_q == tok_i.socket_id);

  always_comb begin
    tok_d = tok_i;
    hit_d = 1'b0;
    if (tok_i.valid && !tok_i.decided) begin
      case (tok_i.func)
        FN_ADD: begin
          // address match of an entry wins over its socket match
          if (addr_eq) begin
            tok_d.decided  = 1'b1;
            tok_d.addr_hit = 1'b1;
            hit_d          = 1'b1;
          end else if (sock_eq) begin
            tok_d.decided = 1'b1;
            hit_d         = 1'b1;
          end
        end
        FN_REMOVE, FN_UPDATE: begin
          if (sock_eq) begin
            tok_d.decided = 1'b1;
            hit_d         = 1'b1;
          end
        end
        FN_QUERY: begin
          if (addr_eq) begin
            tok_d.decided  = 1'b1;
            tok_d.addr_hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // last valid entry rides along for a remove
    if (tok_i.valid && is_last) begin
      tok_d.last_socket  = ent_sock_q;
      tok_d.last_address = ent_addr_q;
      tok_d.last_port    = ent_port_q;
    end
  end

  always_comb begin
    wr_all  = 1'b0;
    wr_port = 1'b0;
    if (wr_i.en) begin
      case (wr_i.mode)
        WR_APPEND: wr_all  = CW'(IDX) == count_i;
        WR_MOVE:   wr_all  = hit_q;
        WR_PORT:   wr_port = hit_q;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      hit_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.valid) begin
        hit_q <= hit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_all) begin
      ent_sock_q <= wr_i.socket_id;
      ent_addr_q <= wr_i.address;
    end
    if (wr_all || wr_port) begin
      ent_port_q <= wr_i.port_number;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/cte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_ctrl
// Sequencer of the table: launches an item into the cell chain, collects it
// at the far end, decides the status, issues the write and holds the result.
// ----------------------------------------------------------------------------
module cte_ctrl
  import cte_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    func_i,
  input  logic [15:0]   socket_id_i,
  input  logic [31:0]   address_i,
  input  logic [15:0]   port_number_i,
  output tok_t          tok_o,
  input  tok_t          tok_i,
  output wr_t           wr_o,
  output logic [CW-1:0] count_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [3:0]    status_o,
  output logic          close_socket_o,
  output logic [4:0]    entry_count_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  tok_t          launch_q, fin_q;
  logic          out_valid_q;
  logic [3:0]    status_q, status_d;
  logic          close_q, close_d;
  logic [4:0]    out_count_q;
  logic          accept, commit;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign commit     = (state_q == S_COMMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_SCAN;
      S_SCAN:   if (tok_i.valid) state_d = S_COMMIT;
      S_COMMIT: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    status_d          = STAT_ABSENT;
    close_d           = 1'b0;
    count_d           = count_q;
    wr_o.en           = 1'b0;
    wr_o.mode         = WR_APPEND;
    wr_o.socket_id    = fin_q.socket_id;
    wr_o.address      = fin_q.address;
    wr_o.port_number  = fin_q.port_number;
    case (fin_q.func)
      FN_ADD: begin
        if (fin_q.decided) begin
          status_d = fin_q.addr_hit ? STAT_DUP_ADDR : STAT_DUP_SOCK;
          close_d  = fin_q.addr_hit;
        end else if (count_q == CW'(TABLE_DEPTH)) begin
          status_d = STAT_FULL;
          close_d  = 1'b1;
        end else begin
          status_d = STAT_ADDED;
          wr_o.en  = commit;
          count_d  = count_q + CW'(1);
        end
      end
      FN_REMOVE: begin
        if (fin_q.decided) begin
          status_d         = STAT_REMOVED;
          wr_o.en          = commit;
          wr_o.mode        = WR_MOVE;
          wr_o.socket_id   = fin_q.last_socket;
          wr_o.address     = fin_q.last_address;
          wr_o.port_number = fin_q.last_port;
          count_d          = count_q - CW'(1);
        end else begin
          status_d = STAT_MISSING;
        end
      end
      FN_UPDATE: begin
        if (fin_q.decided) begin
          status_d  = STAT_UPDATED;
          wr_o.en   = commit;
          wr_o.mode = WR_PORT;
        end else begin
          status_d = STAT_MISSING;
        end
      end
      FN_QUERY: status_d = fin_q.decided ? STAT_FOUND : STAT_ABSENT;
      default:  status_d = STAT_ABSENT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      launch_q    <= '0;
    end else begin
      state_q        <= state_d;
      launch_q.valid <= accept;
      if (accept) begin
        launch_q.func         <= func_i;
        launch_q.socket_id    <= socket_id_i;
        launch_q.address      <= address_i;
        launch_q.port_number  <= port_number_i;
        launch_q.decided      <= 1'b0;
        launch_q.addr_hit     <= 1'b0;
        launch_q.last_socket  <= '0;
        launch_q.last_address <= '0;
        launch_q.last_port    <= '0;
      end
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_SCAN) && tok_i.valid) begin
      fin_q <= tok_i;
    end
    if (commit) begin
      status_q    <= status_d;
      close_q     <= close_d;
      out_count_q <= 5'(count_d);
    end
  end

  assign tok_o          = launch_q;
  assign count_o        = count_q;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign close_socket_o = close_q;
  assign entry_count_o  = out_count_q;

endmodule

// File: rtl/connection_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_table_engine
// Connection table of socket, address and port entries held in a chain of
// cells; add, remove, update and query each pass once down the chain.
// ----------------------------------------------------------------------------
// an item is registered at launch, walks one cell per cycle down the chain,
// is captured at the far end, and its result is registered at the write-back
// the input stays stalled from the accepting edge until the write-back
// a new item is taken while the previous result still waits on a stall
// reset empties the table at once (count to zero); no clearing pass
module connection_table_engine
  import cte_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] socket_id_i,
  input  logic [31:0] address_i,
  input  logic [15:0] port_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic        close_socket_o,
  output logic [4:0]  entry_count_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  tok_t          tok [TABLE_DEPTH+1];
  wr_t           wr;
  logic [CW-1:0] count;

  cte_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .socket_id_i    (socket_id_i),
    .address_i      (address_i),
    .port_number_i  (port_number_i),
    .tok_o          (tok[0]),
    .tok_i          (tok[TABLE_DEPTH]),
    .wr_o           (wr),
    .count_o        (count),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .close_socket_o (close_socket_o),
    .entry_count_o  (entry_count_o)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cte_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count),
      .wr_i    (wr),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
  end

endmodule

// File: rtl/cte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_checker
// Port-level checks of the connection table engine, bound to the top level.
// ----------------------------------------------------------------------------
module cte_checker
  import cte_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  status_o,
  input logic        close_socket_o,
  input logic [4:0]  entry_count_o
);

  // close request only for a duplicate address or a full table
  a_close_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (close_socket_o == ((status_o == STAT_DUP_ADDR) ||
                                        (status_o == STAT_FULL))))
    else $error("close_socket does not match status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= STAT_ABSENT))
    else $error("status code out of range");

  // count never exceeds the table size where it fits in the field
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((TABLE_DEPTH > 31) || (int'(entry_count_o) <= TABLE_DEPTH)))
    else $error("entry_count above table depth");

  // one item at a time: an accepted item closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after an item was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(close_socket_o) &&
       $stable(entry_count_o)))
    else $error("stalled result changed");

endmodule

bind connection_table_engine cte_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_cte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .close_socket_o (close_socket_o),
  .entry_count_o  (entry_count_o)
);

// File: sim/tb_connection_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_connection_table_engine
// Self-checking bench for the connection table engine. A directed table walks
// the empty table, the field extremes, lowest-index priority and the remove
// and update corner cases. Random phases then grow, shrink and mix the table
// from small pools so that duplicates and a full table occur often. Every
// result is checked against a behavioral copy of the table or its typed row.
// ----------------------------------------------------------------------------
module tb_connection_table_engine;
  import cte_pkg::*;

  localparam int DEPTH      = DEF_TABLE_DEPTH;
  localparam int NUM_RANDOM = 600;
  localparam int NUM_DIR    = 24;
  localparam int SETTLE     = DEPTH + 10;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] sock;
    logic [31:0] addr;
    logic [15:0] port;
  } conn_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic       close;
    logic [4:0] count;
  } conn_result_t;

  typedef struct packed {
    conn_item_t   item;
    logic         typed;
    conn_result_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [15:0] socket_id_i;
  logic [31:0] address_i;
  logic [15:0] port_number_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  status_o;
  logic        close_socket_o;
  logic [4:0]  entry_count_o;

  // behavioral copy of the table
  int          tbl_used;
  logic [15:0] tbl_sock [DEPTH];
  logic [31:0] tbl_addr [DEPTH];
  logic [15:0] tbl_port [DEPTH];

  // small pools so that adds collide
  logic [15:0] sock_pool [32];
  logic [31:0] addr_pool [12];
  logic [15:0] port_pool [4];

  conn_result_t pending_results[$];
  int           err_count;
  int           items_sent;
  int           burst_left;

  // directed rows; typed ones carry their own expectation
  dir_row_t dir_rows [NUM_DIR] = '{
    '{'{FN_QUERY,  16'hFFFF, 32'h0000_0000, 16'h0000}, 1'b1, '{STAT_ABSENT,   1'b0, 5'd0}},
    '{'{FN_REMOVE, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{STAT_MISSING,  1'b0, 5'd0}},
    '{'{FN_UPDATE, 16'hFFFF, 32'h0000_0000, 16'hFFFF}, 1'b1, '{STAT_MISSING,  1'b0, 5'd0}},
    '{'{FN_ADD,    16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, '{STAT_ADDED,    1'b0, 5'd1}},
    '{'{FN_ADD,    16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{STAT_ADDED,    1'b0, 5'd2}},
    // address and socket both match entry 0
    '{'{FN_ADD,    16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, '{STAT_DUP_ADDR, 1'b1, 5'd2}},
    // socket hit in entry 0 beats address hit in entry 1
    '{'{FN_ADD,    16'h0000, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{STAT_DUP_SOCK, 1'b0, 5'd2}},
    '{'{FN_ADD,    16'hFFFF, 32'h0000_0000, 16'h0000}, 1'b1, '{STAT_DUP_ADDR, 1'b1, 5'd2}},
    '{'{FN_ADD,    16'h1234, 32'hFFFF_FFFF, 16'h0000}, 1'b1, '{STAT_ADDED,    1'b0, 5'd3}},
    '{'{FN_QUERY,  16'h0000, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{STAT_FOUND,    1'b0, 5'd3}},
    '{'{FN_QUERY,  16'h0000, 32'h0000_0000, 16'hFFFF}, 1'b1, '{STAT_ABSENT,   1'b0, 5'd3}},
    '{'{FN_UPDATE, 16'h8000, 32'h0000_0000, 16'h0005}, 1'b1, '{STAT_MISSING,  1'b0, 5'd3}},
    '{'{FN_UPDATE, 16'hFFFF, 32'h0000_0000, 16'h00FF}, 1'b1, '{STAT_UPDATED,  1'b0, 5'd3}},
    '{'{FN_QUERY,  16'h0000, 32'hFFFF_FFFF, 16'h00FF}, 1'b1, '{STAT_FOUND,    1'b0, 5'd3}},
    '{'{FN_QUERY,  16'h0000, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{STAT_ABSENT,   1'b0, 5'd3}},
    // last entry moves into slot 0
    '{'{FN_REMOVE, 16'h0000, 32'h5555_AAAA, 16'hA5A5}, 1'b1, '{STAT_REMOVED,  1'b0, 5'd2}},
    '{'{FN_QUERY,  16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, '{STAT_ABSENT,   1'b0, 5'd2}},
    '{'{FN_QUERY,  16'hFFFF, 32'hFFFF_FFFF, 16'h0000}, 1'b0, '{STAT_ABSENT,   1'b0, 5'd0}},
    // remove of the last entry
    '{'{FN_REMOVE, 16'hFFFF, 32'hAAAA_5555, 16'h5A5A}, 1'b1, '{STAT_REMOVED,  1'b0, 5'd1}},
    '{'{FN_ADD,    16'h4321, 32'h1234_5678, 16'h8001}, 1'b0, '{STAT_ABSENT,   1'b0, 5'd0}},
    '{'{FN_UPDATE, 16'h1234, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '{STAT_ABSENT,   1'b0, 5'd0}},
    '{'{FN_REMOVE, 16'h1234, 32'h0000_0000, 16'h0000}, 1'b0, '{STAT_ABSENT,   1'b0, 5'd0}},
    '{'{FN_REMOVE, 16'h1234, 32'h0000_0000, 16'h0000}, 1'b1, '{STAT_MISSING,  1'b0, 5'd1}},
    '{'{FN_REMOVE, 16'h4321, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{STAT_REMOVED,  1'b0, 5'd0}}
  };

  connection_table_engine #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .socket_id_i   (socket_id_i),
    .address_i     (address_i),
    .port_number_i (port_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .close_socket_o(close_socket_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

  // apply one operation to the table copy and return its outcome
  function automatic conn_result_t table_predict(conn_item_t it);
    conn_result_t r;
    int           hit;
    bit           decided;
    r.status = STAT_ABSENT;
    r.close  = 1'b0;
    hit      = -1;
    decided  = 1'b0;
    for (int i = 0; i < tbl_used && hit < 0; i++) begin
      if (tbl_sock[i] == it.sock) hit = i;
    end
    case (it.func)
      FN_ADD: begin
        for (int i = 0; i < tbl_used && !decided; i++) begin
          if (tbl_addr[i] == it.addr && tbl_port[i] == it.port) begin
            r.status = STAT_DUP_ADDR;
            r.close  = 1'b1;
            decided  = 1'b1;
          end else if (tbl_sock[i] == it.sock) begin
            r.status = STAT_DUP_SOCK;
            decided  = 1'b1;
          end
        end
        if (!decided) begin
          if (tbl_used >= DEPTH) begin
            r.status = STAT_FULL;
            r.close  = 1'b1;
          end else begin
            tbl_sock[tbl_used] = it.sock;
            tbl_addr[tbl_used] = it.addr;
            tbl_port[tbl_used] = it.port;
            tbl_used++;
            r.status = STAT_ADDED;
          end
        end
      end
      FN_REMOVE: begin
        if (hit >= 0) begin
          tbl_sock[hit] = tbl_sock[tbl_used - 1];
          tbl_addr[hit] = tbl_addr[tbl_used - 1];
          tbl_port[hit] = tbl_port[tbl_used - 1];
          tbl_used--;
          r.status = STAT_REMOVED;
        end else begin
          r.status = STAT_MISSING;
        end
      end
      FN_UPDATE: begin
        if (hit >= 0) begin
          tbl_port[hit] = it.port;
          r.status = STAT_UPDATED;
        end else begin
          r.status = STAT_MISSING;
        end
      end
      default: begin
        for (int i = 0; i < tbl_used && !decided; i++) begin
          if (tbl_addr[i] == it.addr && tbl_port[i] == it.port) begin
            r.status = STAT_FOUND;
            decided  = 1'b1;
          end
        end
      end
    endcase
    r.count = tbl_used[4:0];
    return r;
  endfunction

  // mode 0 grows the table, 1 shrinks it, 2 mixes evenly
  function automatic conn_item_t random_item(int mode);
    conn_item_t it;
    int         pick;
    int         j;
    pick    = $urandom_range(99);
    it.sock = sock_pool[$urandom_range(31)];
    it.addr = addr_pool[$urandom_range(11)];
    it.port = port_pool[$urandom_range(3)];
    if ($urandom_range(99) < 8) begin
      it.func = 2'($urandom_range(3));
      it.sock = 16'($urandom);
      it.addr = $urandom;
      it.port = 16'($urandom);
      return it;
    end
    case (mode)
      0:       it.func = (pick < 70) ? FN_ADD : (pick < 85) ? FN_QUERY :
                         (pick < 90) ? FN_REMOVE : FN_UPDATE;
      1:       it.func = (pick < 55) ? FN_REMOVE : (pick < 70) ? FN_ADD :
                         (pick < 85) ? FN_QUERY : FN_UPDATE;
      default: it.func = pick[1:0];
    endcase
    if ((it.func == FN_REMOVE || it.func == FN_UPDATE) && tbl_used > 0 &&
        $urandom_range(99) < 75) begin
      it.sock = tbl_sock[$urandom_range(tbl_used - 1)];
    end
    if (it.func == FN_REMOVE || it.func == FN_UPDATE) begin
      it.addr = $urandom;
      if ($urandom_range(1)) it.port = 16'($urandom);
    end
    if (it.func == FN_QUERY) begin
      it.sock = 16'($urandom);
      if (tbl_used > 0 && $urandom_range(99) < 60) begin
        j       = $urandom_range(tbl_used - 1);
        it.addr = tbl_addr[j];
        if ($urandom_range(1)) it.port = tbl_port[j];
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic send_item(conn_item_t it, logic typed, conn_result_t typed_res);
    conn_result_t r;
    int           gap;
    in_valid_i    <= 1'b1;
    func_i        <= it.func;
    socket_id_i   <= it.sock;
    address_i     <= it.addr;
    port_number_i <= it.port;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = table_predict(it);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold the sender until every outstanding item has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // result side: checks and a stall pattern that changes its density
  initial begin
    conn_result_t exp_res;
    int           stall_pct;
    int           mode_left;
    out_stall_i = 1'b0;
    stall_pct   = 0;
    mode_left   = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected item status=%0d close=%0b count=%0d",
                                    status_o, close_socket_o, entry_count_o));
        end else begin
          exp_res = pending_results.pop_front();
          if (status_o !== exp_res.status || close_socket_o !== exp_res.close ||
              entry_count_o !== exp_res.count) begin
            report_mismatch($sformatf(
              "expected status=%0d close=%0b count=%0d, got status=%0d close=%0b count=%0d",
              exp_res.status, exp_res.close, exp_res.count,
              status_o, close_socket_o, entry_count_o));
          end
        end
      end
      mode_left--;
      if (mode_left <= 0) begin
        mode_left = $urandom_range(20, 150);
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          default: stall_pct = 70;
        endcase
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    conn_item_t   it;
    conn_result_t no_res;
    int           mode;
    int           phase_len;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FN_ADD;
    socket_id_i   = '0;
    address_i     = '0;
    port_number_i = '0;
    tbl_used      = 0;
    err_count     = 0;
    items_sent    = 0;
    burst_left    = 1;
    no_res        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NUM_DIR; k++) begin
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);
    end
    drain_results();

    while (items_sent < NUM_DIR + NUM_RANDOM) begin
      foreach (sock_pool[k]) sock_pool[k] = 16'($urandom);
      foreach (addr_pool[k]) addr_pool[k] = $urandom;
      foreach (port_pool[k]) port_pool[k] = 16'($urandom);
      mode      = $urandom_range(2);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        it = random_item(mode);
        send_item(it, 1'b0, no_res);
      end
      if ($urandom_range(2) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
